[hdl/abe_pkg.sv]
// Shared constants, types and opcodes of the allocation bitmap engine.
`timescale 1ns / 1ps

package abe_pkg;

    localparam int MAP_BITS   = 1024;
    localparam int WORD_BITS  = 64;
    localparam int NWORDS     = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = $clog2(NWORDS);
    localparam int OFF_W      = $clog2(WORD_BITS);
    localparam int OFFX_W     = OFF_W + 1;
    localparam int CALC_W     = $clog2(MAP_BITS) + 1;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 10;
    localparam int END_W    = 11;
    localparam int DIST_W   = 11;

    localparam logic [OPCODE_W-1:0] OP_SET        = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_TEST       = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SET_RANGE  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLR_RANGE  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_RANGE_ZERO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_FIND       = 3'd6;

    typedef enum logic [2:0] {
        K_SET,
        K_CLEAR,
        K_TEST,
        K_RSET,
        K_RCLEAR,
        K_RZERO,
        K_FIND,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CALC_W-1:0] first;
        logic [CALC_W-1:0] last_excl;
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

endpackage

[hdl/abe_if.sv]
// Request and response channel interfaces of the allocation bitmap engine.
`timescale 1ns / 1ps

interface abe_req_if;
    logic                          valid;
    logic                          ready;
    logic [abe_pkg::OPCODE_W-1:0]  opcode;
    logic [abe_pkg::POS_W-1:0]     bit_position;
    logic [abe_pkg::END_W-1:0]     range_end;

    modport source (output valid, opcode, bit_position, range_end, input ready);
    modport sink   (input valid, opcode, bit_position, range_end, output ready);
endinterface

interface abe_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        flag;
    logic [abe_pkg::DIST_W-1:0]  found_distance;

    modport source (output valid, flag, found_distance, input ready);
    modport sink   (input valid, flag, found_distance, output ready);
endinterface

[hdl/abe_front.sv]
// Front end: accepts request words, decodes them and saturates range ends.
`timescale 1ns / 1ps

module abe_front (
    abe_req_if.sink         i_req,
    input  logic            i_full,
    output logic            o_push,
    output abe_pkg::t_cmd   o_cmd
);

    logic        in_map;
    logic [31:0] end_sat;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    assign in_map  = 32'(i_req.bit_position) < 32'(abe_pkg::MAP_BITS);
    assign end_sat = (32'(i_req.range_end) > 32'(abe_pkg::MAP_BITS)) ?
                     32'(abe_pkg::MAP_BITS) : 32'(i_req.range_end);

    always_comb begin
        o_cmd.first     = abe_pkg::CALC_W'(i_req.bit_position);
        o_cmd.last_excl = end_sat[abe_pkg::CALC_W-1:0];
        unique case (i_req.opcode)
            abe_pkg::OP_SET:        o_cmd.kind = in_map ? abe_pkg::K_SET   : abe_pkg::K_NOP;
            abe_pkg::OP_CLEAR:      o_cmd.kind = in_map ? abe_pkg::K_CLEAR : abe_pkg::K_NOP;
            abe_pkg::OP_TEST:       o_cmd.kind = in_map ? abe_pkg::K_TEST  : abe_pkg::K_NOP;
            abe_pkg::OP_SET_RANGE:  o_cmd.kind = abe_pkg::K_RSET;
            abe_pkg::OP_CLR_RANGE:  o_cmd.kind = abe_pkg::K_RCLEAR;
            abe_pkg::OP_RANGE_ZERO: o_cmd.kind = abe_pkg::K_RZERO;
            abe_pkg::OP_FIND:       o_cmd.kind = abe_pkg::K_FIND;
            default:                o_cmd.kind = abe_pkg::K_NOP;
        endcase
    end

endmodule

[hdl/abe_cmd_fifo.sv]
// Short command queue between front end and back end.
`timescale 1ns / 1ps

module abe_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  abe_pkg::t_cmd   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output abe_pkg::t_cmd   o_data
);

    abe_pkg::t_cmd                 r_mem [abe_pkg::FIFO_DEPTH];
    logic [abe_pkg::FIFO_AW-1:0]   r_wr_ptr;
    logic [abe_pkg::FIFO_AW-1:0]   r_rd_ptr;
    logic [abe_pkg::FIFO_AW:0]     r_count;
    logic [abe_pkg::FIFO_AW-1:0]   n_wr_ptr;
    logic [abe_pkg::FIFO_AW-1:0]   n_rd_ptr;
    logic [abe_pkg::FIFO_AW:0]     n_count;

    assign o_full  = r_count == (abe_pkg::FIFO_AW + 1)'(abe_pkg::FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == abe_pkg::FIFO_AW'(abe_pkg::FIFO_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == abe_pkg::FIFO_AW'(abe_pkg::FIFO_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hdl/abe_back.sv]
// Back end: holds the bitmap, executes commands word by word, drives results.
`timescale 1ns / 1ps

module abe_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  abe_pkg::t_cmd   i_cmd,
    output logic            o_pop,
    abe_rsp_if.source       o_rsp
);

    localparam logic [abe_pkg::ADDR_W-1:0] LAST_WORD =
        abe_pkg::ADDR_W'(abe_pkg::NWORDS - 1);
    localparam logic [abe_pkg::WORD_BITS-1:0] MSB_ONE =
        {1'b1, {(abe_pkg::WORD_BITS - 1){1'b0}}};

    function automatic logic [abe_pkg::WORD_BITS-1:0] range_mask(
        input logic [abe_pkg::ADDR_W-1:0] w,
        input logic [abe_pkg::CALC_W-1:0] from,
        input logic [abe_pkg::CALC_W-1:0] upto
    );
        logic [abe_pkg::CALC_W-1:0]    base;
        logic [abe_pkg::CALC_W-1:0]    top;
        logic [abe_pkg::CALC_W-1:0]    lo;
        logic [abe_pkg::CALC_W-1:0]    hi;
        logic [abe_pkg::OFFX_W-1:0]    lo_off;
        logic [abe_pkg::OFFX_W-1:0]    hi_off;
        logic [abe_pkg::WORD_BITS-1:0] ones;
        base   = abe_pkg::CALC_W'(w) << abe_pkg::OFF_W;
        top    = base + abe_pkg::CALC_W'(abe_pkg::WORD_BITS);
        lo     = (from > base) ? from : base;
        hi     = (upto < top) ? upto : top;
        ones   = '1;
        lo_off = abe_pkg::OFFX_W'(lo - base);
        hi_off = abe_pkg::OFFX_W'(hi - base);
        if (lo >= hi) begin
            return '0;
        end
        return (ones >> lo_off) & ~(ones >> hi_off);
    endfunction

    // offset from MSB of the lowest set bit, i.e. the highest position in the word
    function automatic logic [abe_pkg::OFF_W-1:0] last_offset(
        input logic [abe_pkg::WORD_BITS-1:0] v
    );
        logic [abe_pkg::OFF_W-1:0] k;
        k = '0;
        for (int i = abe_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                k = abe_pkg::OFF_W'(abe_pkg::WORD_BITS - 1 - i);
            end
        end
        return k;
    endfunction

    logic [abe_pkg::WORD_BITS-1:0] r_map [abe_pkg::NWORDS];
    abe_pkg::t_state               r_state;
    abe_pkg::t_state               n_state;
    abe_pkg::t_cmd                 r_cmd;
    abe_pkg::t_cmd                 n_cmd;
    logic [abe_pkg::ADDR_W-1:0]    r_word;
    logic [abe_pkg::ADDR_W-1:0]    n_word;
    logic                          r_zero;
    logic                          n_zero;
    logic [abe_pkg::DIST_W-1:0]    r_found;
    logic [abe_pkg::DIST_W-1:0]    n_found;
    logic                          r_out_valid;
    logic                          r_out_flag;
    logic [abe_pkg::DIST_W-1:0]    r_out_dist;

    logic                          out_free;
    logic [abe_pkg::ADDR_W-1:0]    rd_idx;
    logic [abe_pkg::WORD_BITS-1:0] word_rd;
    logic [abe_pkg::WORD_BITS-1:0] bit_m;
    logic [abe_pkg::WORD_BITS-1:0] rmask;
    logic                          zero_next;
    logic [abe_pkg::CALC_W-1:0]    hit_pos;
    logic [abe_pkg::DIST_W-1:0]    found_next;
    logic                          wr_en;
    logic [abe_pkg::WORD_BITS-1:0] wr_data;
    logic                          ld_out;
    logic                          out_flag;
    logic [abe_pkg::DIST_W-1:0]    out_dist;

    assign out_free         = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.flag           = r_out_flag;
    assign o_rsp.found_distance = r_out_dist;

    assign rd_idx  = (r_state == abe_pkg::ST_WALK) ? r_word :
                     i_cmd.first[abe_pkg::OFF_W +: abe_pkg::ADDR_W];
    assign word_rd = r_map[rd_idx];
    assign bit_m   = MSB_ONE >> i_cmd.first[abe_pkg::OFF_W-1:0];
    assign rmask   = range_mask(r_word, r_cmd.first, r_cmd.last_excl);

    assign zero_next  = r_zero && ((word_rd & rmask) == '0);
    assign hit_pos    = abe_pkg::CALC_W'({r_word, last_offset(word_rd)});
    assign found_next = (word_rd != '0) ?
        abe_pkg::DIST_W'(abe_pkg::CALC_W'(abe_pkg::MAP_BITS) - hit_pos) : r_found;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_word   = r_word;
        n_zero   = r_zero;
        n_found  = r_found;
        o_pop    = 1'b0;
        wr_en    = 1'b0;
        wr_data  = word_rd;
        ld_out   = 1'b0;
        out_flag = 1'b0;
        out_dist = '0;
        unique case (r_state)
            abe_pkg::ST_IDLE: begin
                if (i_valid) begin
                    priority if (i_cmd.kind == abe_pkg::K_RSET ||
                                 i_cmd.kind == abe_pkg::K_RCLEAR ||
                                 i_cmd.kind == abe_pkg::K_RZERO ||
                                 i_cmd.kind == abe_pkg::K_FIND) begin
                        o_pop   = 1'b1;
                        n_cmd   = i_cmd;
                        n_word  = '0;
                        n_zero  = 1'b1;
                        n_found = '0;
                        n_state = abe_pkg::ST_WALK;
                    end else if (out_free) begin
                        o_pop  = 1'b1;
                        ld_out = 1'b1;
                        unique case (i_cmd.kind)
                            abe_pkg::K_SET: begin
                                wr_en    = 1'b1;
                                wr_data  = word_rd | bit_m;
                                out_flag = (word_rd & bit_m) == '0;
                            end
                            abe_pkg::K_CLEAR: begin
                                wr_en    = 1'b1;
                                wr_data  = word_rd & ~bit_m;
                                out_flag = (word_rd & bit_m) != '0;
                            end
                            abe_pkg::K_TEST: begin
                                out_flag = (word_rd & bit_m) != '0;
                            end
                            default: begin
                                out_flag = 1'b0;
                            end
                        endcase
                    end else begin
                        o_pop = 1'b0;
                    end
                end
            end
            abe_pkg::ST_WALK: begin
                if (r_word != LAST_WORD || out_free) begin
                    n_word  = r_word + 1'b1;
                    n_zero  = zero_next;
                    n_found = found_next;
                    unique case (r_cmd.kind)
                        abe_pkg::K_RSET: begin
                            wr_en   = 1'b1;
                            wr_data = word_rd | rmask;
                        end
                        abe_pkg::K_RCLEAR: begin
                            wr_en   = 1'b1;
                            wr_data = word_rd & ~rmask;
                        end
                        default: begin
                            wr_en = 1'b0;
                        end
                    endcase
                    if (r_word == LAST_WORD) begin
                        ld_out   = 1'b1;
                        out_flag = (r_cmd.kind == abe_pkg::K_RZERO) && zero_next;
                        out_dist = (r_cmd.kind == abe_pkg::K_FIND) ? found_next : '0;
                        n_state  = abe_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = abe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= abe_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < abe_pkg::NWORDS; i++) begin
                r_map[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_map[rd_idx] <= wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_word  <= n_word;
        r_zero  <= n_zero;
        r_found <= n_found;
        if (ld_out) begin
            r_out_flag <= out_flag;
            r_out_dist <= out_dist;
        end
    end

endmodule

[hdl/allocation_bitmap_engine_core.sv]
// Allocation bitmap engine: 1024-bit map with bit, range and find operations.
//
// Request channel i_req carries opcode, bit_position and range_end; each
// accepted word yields exactly one word on o_rsp (flag, found_distance),
// in order. Both channels move a word when valid and ready are high.
// The front end decodes requests into a two-entry command queue, so i_req
// is ready whenever the queue has room. The back end owns the bitmap.
// Single-bit set, clear and test are executed as the command is popped;
// set range, clear range, range-zero test and find pop the command and
// then visit each bitmap word (16) in turn, as the single bitmap write
// port allows, and the back end pops no new command until the walk ends.
// A request is registered in the command queue and its reply in the
// result register; a range or find operation walks the map in between.
// Reset (i_rst_n low, synchronous) clears the whole map, the queue and the
// result register. A stalled o_rsp holds its word; the back end stops at
// the last step of an item until the result register frees, and the queue
// keeps taking requests until it fills.
`timescale 1ns / 1ps

module allocation_bitmap_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    abe_req_if.sink     i_req,
    abe_rsp_if.source   o_rsp
);

    abe_pkg::t_cmd front_cmd;
    abe_pkg::t_cmd queue_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          queue_valid;

    abe_front u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    abe_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    abe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

[bench/allocation_bitmap_engine_core_checker.sv]
// Checker for the allocation bitmap engine: tracks the map, predicts each reply and compares.
`timescale 1ns / 1ps

module allocation_bitmap_engine_core_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    abe_req_if   i_req_mon,
    abe_rsp_if   i_rsp_mon,
    output int   o_mismatches,
    output int   o_pending
);
    import abe_pkg::*;

    typedef struct packed {
        logic              flag;
        logic [DIST_W-1:0] distance;
    } bitmap_reply_t;

    // index p is map position p, so position 0 is the MSB of word 0
    logic [0:MAP_BITS-1] alloc_map;
    bitmap_reply_t       replies_due[$];
    int                  mismatch_count = 0;
    int                  words_seen     = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] reply word %0d: %s", $realtime, words_seen, what);
    endtask

    function automatic bitmap_reply_t apply_request(input logic [OPCODE_W-1:0] op,
                                                    input logic [POS_W-1:0]    pos,
                                                    input logic [END_W-1:0]    lim);
        bitmap_reply_t r;
        int            stop;
        int            highest;
        int            p;
        r       = '0;
        stop    = (int'(lim) > MAP_BITS) ? MAP_BITS : int'(lim);
        highest = -1;
        case (op)
            OP_SET: begin
                if (int'(pos) < MAP_BITS) begin
                    r.flag         = !alloc_map[pos];
                    alloc_map[pos] = 1'b1;
                end
            end
            OP_CLEAR: begin
                if (int'(pos) < MAP_BITS) begin
                    r.flag         = alloc_map[pos];
                    alloc_map[pos] = 1'b0;
                end
            end
            OP_TEST: begin
                if (int'(pos) < MAP_BITS)
                    r.flag = alloc_map[pos];
            end
            OP_SET_RANGE: begin
                for (p = int'(pos); p < stop; p++)
                    alloc_map[p] = 1'b1;
            end
            OP_CLR_RANGE: begin
                for (p = int'(pos); p < stop; p++)
                    alloc_map[p] = 1'b0;
            end
            OP_RANGE_ZERO: begin
                r.flag = 1'b1;
                for (p = int'(pos); p < stop; p++)
                    if (alloc_map[p])
                        r.flag = 1'b0;
            end
            OP_FIND: begin
                for (p = 0; p < MAP_BITS; p++)
                    if (alloc_map[p])
                        highest = p;
                if (highest >= 0)
                    r.distance = DIST_W'(MAP_BITS - highest);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        bitmap_reply_t want;
        if (!i_rst_n) begin
            alloc_map = '0;
            replies_due.delete();
        end else begin
            if (i_req_mon.valid && i_req_mon.ready)
                replies_due.push_back(apply_request(i_req_mon.opcode, i_req_mon.bit_position,
                                                    i_req_mon.range_end));
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word, flag %0b distance %0d",
                                              i_rsp_mon.flag, i_rsp_mon.found_distance));
                end else begin
                    want = replies_due.pop_front();
                    if (i_rsp_mon.flag !== want.flag)
                        report_mismatch($sformatf("flag %0b, expected %0b",
                                                  i_rsp_mon.flag, want.flag));
                    if (i_rsp_mon.found_distance !== want.distance)
                        report_mismatch($sformatf("found_distance %0d, expected %0d",
                                                  i_rsp_mon.found_distance, want.distance));
                end
                words_seen++;
            end
        end
        o_pending <= replies_due.size();
    end

endmodule

[bench/allocation_bitmap_engine_core_test.sv]
// Top of the allocation bitmap engine regression: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module allocation_bitmap_engine_core_test;
    import abe_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED   = 3'd7;
    localparam int                  CYCLE_LIMIT = 400000;
    localparam int                  RANDOM_WORDS = 1025;

    logic i_clk;
    logic i_rst_n;
    logic no_idle;
    int   mismatches;
    int   pending;
    int   cycle_count = 0;
    int   hot_base;

    abe_req_if req_ch ();
    abe_rsp_if rsp_ch ();

    allocation_bitmap_engine_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    allocation_bitmap_engine_core_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_ch),
        .i_rsp_mon    (rsp_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("allocation_bitmap_engine_core regression: fail");
            $finish;
        end
    end

    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [END_W-1:0] lim);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.bit_position <= pos;
        req_ch.range_end    <= lim;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_random_word();
        int               sel;
        int               span;
        logic [OPCODE_W-1:0] op;
        logic [POS_W-1:0] pos;
        logic [END_W-1:0] lim;
        sel = $urandom_range(0, 99);
        if (sel < 20)      op = OP_SET;
        else if (sel < 32) op = OP_CLEAR;
        else if (sel < 44) op = OP_TEST;
        else if (sel < 56) op = OP_SET_RANGE;
        else if (sel < 66) op = OP_CLR_RANGE;
        else if (sel < 80) op = OP_RANGE_ZERO;
        else if (sel < 96) op = OP_FIND;
        else               op = OP_UNUSED;
        if ($urandom_range(0, 3) == 0)
            pos = POS_W'($urandom_range(0, MAP_BITS - 1));
        else
            pos = POS_W'(hot_base + int'($urandom_range(0, 47)));
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            span = $urandom_range(0, 70);
            lim  = END_W'(int'(pos) + span);
        end else if (sel < 8) begin
            span = $urandom_range(0, MAP_BITS);
            lim  = END_W'(int'(pos) + span);
        end else begin
            lim = END_W'($urandom_range(0, 2047));
        end
        send_word(op, pos, lim);
    endtask

    // receive side: random stalls, two long hold-offs to back the block up
    initial begin : rsp_side
        int stall;
        int taken;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (taken == 30 || taken == 500)
                stall = 300;
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            taken++;
        end
    end

    initial begin : stimulus
        int n;
        no_idle             <= 1'b0;
        hot_base             = 0;
        req_ch.valid        <= 1'b0;
        req_ch.opcode       <= OP_SET;
        req_ch.bit_position <= '0;
        req_ch.range_end    <= '0;
        i_rst_n             <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty map, map edges, saturation, empty ranges, word boundary, unused opcode
        send_word(OP_FIND, 10'd0, 11'd0);
        send_word(OP_TEST, 10'd0, 11'd0);
        send_word(OP_TEST, 10'd1023, 11'd2047);
        send_word(OP_SET, 10'd0, 11'd0);
        send_word(OP_SET, 10'd0, 11'd0);
        send_word(OP_SET, 10'd1023, 11'd0);
        send_word(OP_TEST, 10'd1023, 11'd0);
        send_word(OP_FIND, 10'd0, 11'd0);
        send_word(OP_CLEAR, 10'd1023, 11'd0);
        send_word(OP_CLEAR, 10'd1023, 11'd0);
        send_word(OP_FIND, 10'd0, 11'd0);
        send_word(OP_RANGE_ZERO, 10'd0, 11'd1);
        send_word(OP_RANGE_ZERO, 10'd1, 11'd1024);
        send_word(OP_SET_RANGE, 10'd5, 11'd2047);
        send_word(OP_FIND, 10'd0, 11'd0);
        send_word(OP_RANGE_ZERO, 10'd100, 11'd50);
        send_word(OP_CLR_RANGE, 10'd10, 11'd10);
        send_word(OP_TEST, 10'd10, 11'd0);
        send_word(OP_CLR_RANGE, 10'd0, 11'd1024);
        send_word(OP_FIND, 10'd0, 11'd0);
        send_word(OP_SET_RANGE, 10'd63, 11'd65);
        send_word(OP_TEST, 10'd64, 11'd0);
        send_word(OP_RANGE_ZERO, 10'd62, 11'd63);
        send_word(OP_RANGE_ZERO, 10'd0, 11'd2047);
        send_word(OP_UNUSED, 10'd1023, 11'd2047);
        send_word(OP_SET_RANGE, 10'd0, 11'd0);
        send_word(OP_CLR_RANGE, 10'd0, 11'd2047);
        wait_drained();

        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 100 == 0) begin
                no_idle <= ($urandom_range(0, 3) == 0);
                hot_base = $urandom_range(0, MAP_BITS - 48);
            end
            if (n == 300)
                wait_drained();
            send_random_word();
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("allocation_bitmap_engine_core regression: pass");
        else
            $display("allocation_bitmap_engine_core regression: fail");
        $finish;
    end

endmodule

[sim.f]
hdl/abe_pkg.sv
hdl/abe_if.sv
hdl/abe_front.sv
hdl/abe_cmd_fifo.sv
hdl/abe_back.sv
hdl/allocation_bitmap_engine_core.sv
bench/allocation_bitmap_engine_core_checker.sv
bench/allocation_bitmap_engine_core_test.sv
